/* hw/rtl/pnf_pkg.sv */
package pnf_pkg;

   // Sequencer states of the field formatter.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   // Conversion codes; codes above FN_CHAR are unknown and give an empty body.
   localparam logic [2:0] FN_SDEC16 = 3'd0;
   localparam logic [2:0] FN_SDEC32 = 3'd1;
   localparam logic [2:0] FN_UDEC16 = 3'd2;
   localparam logic [2:0] FN_HEXL   = 3'd3;
   localparam logic [2:0] FN_HEXU   = 3'd4;
   localparam logic [2:0] FN_CHAR   = 3'd5;

   // Field limits.
   localparam int          DIGITS_MAX = 10;
   localparam int          IDX_W      = $clog2(DIGITS_MAX);
   localparam logic [3:0]  WIDTH_MAX  = 4'd9;

   // Reciprocal of ten: floor(n * RECIP_TEN / 2**RECIP_SHIFT) == n / 10 for any 32-bit n.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // ASCII codes.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // One step of the shared digit unit: the reduced value and the digit split off.
   typedef struct packed {
      logic [31:0] quot;
      logic [3:0]  digit;
   } step_type;

   // Turns one digit into its ASCII character.
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] alpha;
      alpha = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d > 4'd9) begin
         digit_char = alpha + {4'd0, d} - 8'd10;
      end else begin
         digit_char = CH_ZERO + {4'd0, d};
      end
   endfunction

endpackage

/* hw/rtl/printf_number_formatter.sv */
// Channel   Ports                                        Transfer
// request   start, busy, req_func/width/zero_pad/value   start high while busy is low
// response  rsp_valid, rsp_char_out, rsp_last            every cycle rsp_valid is high
//
// A field is accepted, then each decimal digit passes a multiply state and a digit
// state, each hex digit a digit state alone, then the output characters are emitted.
// Decimal digits come from the shared divide-by-ten unit: a registered
// reciprocal multiply followed by a subtract.
// Reset is synchronous and active high; it returns the sequencer to idle.
// The receiver cannot stall; characters leave at one per cycle.
module printf_number_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_width,
   input  logic        req_zero_pad,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);
   import pnf_pkg::*;

   state_type   state_ff, state_in;
   logic        accept;

   // Item registers.
   logic [31:0] mag_ff;
   logic [3:0]  width_ff;
   logic        zpad_ff;
   logic        neg_ff;
   logic        hex_ff;
   logic        upper_ff;
   logic        char_mode_ff;
   logic [7:0]  char_ff;
   logic [3:0]  ndig_ff;
   logic [3:0]  k_ff;
   logic [3:0]  digits_ff [DIGITS_MAX];

   // Output registers.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   // Decode of the incoming item.
   logic [15:0] lo16;
   logic        acc_neg;
   logic [31:0] acc_mag;
   logic        acc_dec;
   logic        acc_hex;

   // Field layout.
   logic [3:0]  body;
   logic [3:0]  pad;
   logic [3:0]  prefix;
   logic [3:0]  total;
   logic [3:0]  body_pos;
   logic [IDX_W-1:0] dig_idx;

   step_type    step;

   pnf_digit_unit u_digit (
      .clock (clock),
      .hex   (hex_ff),
      .mag   (mag_ff),
      .step  (step)
   );

   assign accept = start && !busy;
   assign lo16   = req_value[15:0];

   // Sign and magnitude of the argument per conversion.
   always_comb begin
      acc_neg = 1'b0;
      acc_mag = req_value;
      acc_dec = 1'b0;
      acc_hex = 1'b0;
      case (req_func)
         FN_SDEC16: begin
            acc_dec = 1'b1;
            acc_neg = lo16[15];
            acc_mag = lo16[15] ? {16'd0, 16'(~lo16 + 16'd1)} : {16'd0, lo16};
         end
         FN_SDEC32: begin
            acc_dec = 1'b1;
            acc_neg = req_value[31];
            acc_mag = req_value[31] ? (~req_value + 32'd1) : req_value;
         end
         FN_UDEC16: begin
            acc_dec = 1'b1;
            acc_mag = {16'd0, lo16};
         end
         FN_HEXL, FN_HEXU: begin
            acc_hex = 1'b1;
         end
         default: begin
            acc_mag = req_value;
         end
      endcase
   end

   // Field layout: padding and sign (sign first when zero padded), then the body.
   assign body     = ndig_ff + {3'd0, neg_ff};
   assign pad      = (width_ff > body) ? (width_ff - body) : 4'd0;
   assign prefix   = pad + {3'd0, neg_ff};
   assign total    = prefix + ndig_ff;
   assign body_pos = k_ff - prefix;
   assign dig_idx  = IDX_W'(ndig_ff - 4'd1 - body_pos);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (acc_dec) begin
                  state_in = ST_MUL;
               end else if (acc_hex) begin
                  state_in = ST_DIGIT;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (step.quot == 32'd0) begin
               state_in = ST_EMIT;
            end else if (hex_ff) begin
               state_in = ST_DIGIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (k_ff + 4'd1 >= total) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: busy and the next character.
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_char_in  = CH_SPACE;
      case (state_ff)
         ST_EMIT: begin
            rsp_valid_in = (k_ff < total);
            rsp_last_in  = (k_ff + 4'd1 == total);
            if (k_ff < prefix) begin
               if (zpad_ff) begin
                  rsp_char_in = (neg_ff && k_ff == 4'd0) ? CH_MINUS : CH_ZERO;
               end else begin
                  rsp_char_in = (neg_ff && k_ff == pad) ? CH_MINUS : CH_SPACE;
               end
            end else if (char_mode_ff) begin
               rsp_char_in = char_ff;
            end else begin
               rsp_char_in = digit_char(digits_ff[dig_idx], upper_ff);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         ndig_ff      <= 4'd0;
         k_ff         <= 4'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         if (accept) begin
            ndig_ff <= (req_func == FN_CHAR) ? 4'd1 : 4'd0;
            k_ff    <= 4'd0;
         end else if (state_ff == ST_DIGIT) begin
            ndig_ff <= ndig_ff + 4'd1;
         end else if (state_ff == ST_EMIT) begin
            k_ff <= k_ff + 4'd1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      if (accept) begin
         mag_ff       <= acc_mag;
         width_ff     <= (req_width > WIDTH_MAX) ? WIDTH_MAX : req_width;
         zpad_ff      <= req_zero_pad;
         neg_ff       <= acc_neg;
         hex_ff       <= acc_hex;
         upper_ff     <= (req_func == FN_HEXU);
         char_mode_ff <= (req_func == FN_CHAR);
         char_ff      <= req_value[7:0];
      end else if (state_ff == ST_DIGIT) begin
         mag_ff                     <= step.quot;
         digits_ff[IDX_W'(ndig_ff)] <= step.digit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef ASSERT_OFF
   // An accepted field always leaves idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted field did not make the block busy");

   // A character transfer only follows a cycle of the emit state.
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("character transfer outside the emit phase");

   // The digit count never exceeds the ten digits of a 32-bit value.
   a_ndig_bound: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= 4'(DIGITS_MAX))
      else $error("digit count overflow");

   // Last is only marked on a transfer.
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last marked without a transfer");

   // No field is longer than eleven characters.
   a_field_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (total <= 4'd11))
      else $error("field longer than eleven characters");
`endif

endmodule

/* hw/rtl/pnf_digit_unit.sv */
module pnf_digit_unit (
   input  logic              clock,
   input  logic              hex,
   input  logic [31:0]       mag,
   output pnf_pkg::step_type step
);
   import pnf_pkg::*;

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [31:0] dec_quot;
   logic [31:0] tenfold;
   logic [31:0] dec_rem;

   // Reciprocal multiply by one tenth; the product is registered.
   assign prod_in = 64'(mag) * 64'(RECIP_TEN);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Quotient and remainder of the decimal step, taken from the registered product.
   assign dec_quot = 32'(prod_ff >> RECIP_SHIFT);
   assign tenfold  = (dec_quot << 3) + (dec_quot << 1);
   assign dec_rem  = mag - tenfold;

   // Hex steps are a plain nibble shift.
   always_comb begin
      if (hex) begin
         step.quot  = mag >> 4;
         step.digit = mag[3:0];
      end else begin
         step.quot  = dec_quot;
         step.digit = dec_rem[3:0];
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import pnf_pkg::*;

   // Conversion codes above FN_CHAR are unknown to the block.
   localparam logic [2:0] FN_UNKNOWN_6 = 3'd6;
   localparam logic [2:0] FN_UNKNOWN_7 = 3'd7;

   localparam int NUM_DIRECTED  = 23;
   localparam int FIELDS_PER_PHASE = 115;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 300000;

   // One character of a formatted field as it should leave the block.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   // One field request; typed rows carry their expected text.
   typedef struct {
      logic [2:0]  func;
      logic [3:0]  width;
      logic        zero_pad;
      logic [31:0] value;
      bit          typed;
      string       text;
   } field_req_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [3:0]  req_width;
   logic        req_zero_pad;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   field_char_type pending_chars[$];
   field_req_type  directed_rows [NUM_DIRECTED];
   int             idle_pct;
   int             error_count;
   int             cycle_count;

   printf_number_formatter i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_width    (req_width),
      .req_zero_pad (req_zero_pad),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Formats one field and queues its characters, the final one marked.
   function automatic void predict_field(input logic [2:0] fn, input logic [3:0] wd,
                                         input logic zp, input logic [31:0] v);
      logic [7:0]  digits[$];
      logic [7:0]  chars[$];
      logic        neg;
      logic [31:0] mag;
      logic [3:0]  nib;
      logic [7:0]  alpha;
      int          wd_eff;
      int          pad;
      neg   = 1'b0;
      mag   = '0;
      alpha = (fn == FN_HEXU) ? CH_UPPER_A : CH_LOWER_A;
      case (fn)
         FN_SDEC16: begin
            neg = v[15];
            mag = neg ? 32'h0001_0000 - {16'h0, v[15:0]} : {16'h0, v[15:0]};
         end
         FN_SDEC32: begin
            neg = v[31];
            mag = neg ? 32'd0 - v : v;
         end
         FN_UDEC16: mag = {16'h0, v[15:0]};
         FN_HEXL, FN_HEXU: mag = v;
         FN_CHAR: digits.push_back(v[7:0]);
         default: ;
      endcase
      // Digits come out least significant first, so build the body from the front.
      if (fn == FN_SDEC16 || fn == FN_SDEC32 || fn == FN_UDEC16) begin
         do begin
            digits.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
      end else if (fn == FN_HEXL || fn == FN_HEXU) begin
         do begin
            nib = mag[3:0];
            digits.push_front((nib > 4'd9) ? alpha + 8'(nib) - 8'd10 : CH_ZERO + 8'(nib));
            mag = mag >> 4;
         end while (mag != 0);
      end
      // Widths above nine saturate; the sign counts toward the width.
      wd_eff = (wd > WIDTH_MAX) ? int'(WIDTH_MAX) : int'(wd);
      pad    = wd_eff - digits.size() - int'(neg);
      if (pad < 0) begin
         pad = 0;
      end
      if (zp) begin
         if (neg) begin
            chars.push_back(CH_MINUS);
         end
         repeat (pad) chars.push_back(CH_ZERO);
      end else begin
         repeat (pad) chars.push_back(CH_SPACE);
         if (neg) begin
            chars.push_back(CH_MINUS);
         end
      end
      foreach (digits[k]) chars.push_back(digits[k]);
      foreach (chars[k]) begin
         pending_chars.push_back(field_char_type'{chars[k], k == chars.size() - 1});
      end
   endfunction

   // Presents one field after an optional idle gap and waits for its transfer.
   task automatic send_field(input field_req_type row);
      int gap;
      int i;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_func     <= row.func;
      req_width    <= row.width;
      req_zero_pad <= row.zero_pad;
      req_value    <= row.value;
      do @(posedge clock); while (busy);
      // The transfer happened at this edge; queue what it should produce.
      if (row.typed) begin
         for (i = 0; i < row.text.len(); i++) begin
            pending_chars.push_back(field_char_type'{row.text[i], i == row.text.len() - 1});
         end
      end else begin
         predict_field(row.func, row.width, row.zero_pad, row.value);
      end
   endtask

   // Holds the request side quiet until every queued character has arrived.
   task automatic pause_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   // Compares each character transfer with the oldest queued character.
   always @(posedge clock) begin : check_chars
      field_char_type want;
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character transfer: char_out %h last %b",
                   rsp_char_out, rsp_last);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_out !== want.ch) begin
               $error("char_out: expected %h, got %h", want.ch, rsp_char_out);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      field_req_type row;
      int            phase;
      int            pct [3];
      reset        = 1'b1;
      start        = 1'b0;
      req_func     = '0;
      req_width    = '0;
      req_zero_pad = 1'b0;
      req_value    = '0;
      idle_pct     = 0;
      error_count  = 0;
      cycle_count  = 0;
      pct          = '{0, 60, 26};

      // Extremes, every conversion, padding styles and the empty field.
      directed_rows = '{
         '{FN_SDEC16,    4'd0,  1'b0, 32'h0000_8000, 1'b1, "-32768"},
         '{FN_SDEC16,    4'd0,  1'b0, 32'h0000_7FFF, 1'b1, "32767"},
         '{FN_SDEC16,    4'd9,  1'b1, 32'hFFFF_FFFF, 1'b1, "-00000001"},
         '{FN_SDEC16,    4'd9,  1'b0, 32'h1234_FFFF, 1'b1, "       -1"},
         '{FN_SDEC16,    4'd3,  1'b1, 32'hFFFF_FF85, 1'b0, ""},
         '{FN_SDEC32,    4'd0,  1'b0, 32'h8000_0000, 1'b1, "-2147483648"},
         '{FN_SDEC32,    4'd15, 1'b1, 32'h8000_0000, 1'b1, "-2147483648"},
         '{FN_SDEC32,    4'd0,  1'b0, 32'h7FFF_FFFF, 1'b1, "2147483647"},
         '{FN_SDEC32,    4'd0,  1'b0, 32'h0000_0000, 1'b1, "0"},
         '{FN_SDEC32,    4'd15, 1'b0, 32'hFFFF_FFFF, 1'b0, ""},
         '{FN_UDEC16,    4'd0,  1'b0, 32'hFFFF_FFFF, 1'b1, "65535"},
         '{FN_UDEC16,    4'd5,  1'b1, 32'hABCD_0000, 1'b1, "00000"},
         '{FN_UDEC16,    4'd0,  1'b0, 32'h0000_8000, 1'b0, ""},
         '{FN_HEXL,      4'd0,  1'b0, 32'hDEAD_BEEF, 1'b1, "deadbeef"},
         '{FN_HEXU,      4'd0,  1'b0, 32'hDEAD_BEEF, 1'b1, "DEADBEEF"},
         '{FN_HEXL,      4'd9,  1'b1, 32'h0000_0000, 1'b1, "000000000"},
         '{FN_HEXU,      4'd10, 1'b0, 32'h0000_000A, 1'b1, "        A"},
         '{FN_CHAR,      4'd0,  1'b0, 32'h0000_0041, 1'b1, "A"},
         '{FN_CHAR,      4'd2,  1'b1, 32'hFFFF_FF00, 1'b0, ""},
         '{FN_CHAR,      4'd0,  1'b0, 32'h0000_00FF, 1'b0, ""},
         '{FN_UNKNOWN_6, 4'd0,  1'b0, 32'h1234_5678, 1'b1, ""},
         '{FN_UNKNOWN_7, 4'd4,  1'b0, 32'hFFFF_FFFF, 1'b1, "    "},
         '{FN_UNKNOWN_6, 4'd9,  1'b1, 32'h0000_0000, 1'b1, "000000000"}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_field(directed_rows[r]);
      pause_until_drained();

      // Random fields, one idling style per phase.
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = pct[phase];
         repeat (FIELDS_PER_PHASE) begin
            row.func     = 3'($urandom_range(7));
            row.width    = ($urandom_range(1) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(9));
            row.zero_pad = 1'($urandom_range(1));
            row.typed    = 1'b0;
            row.text     = "";
            // Mix full-range values with small, negative and 16-bit edge values.
            case ($urandom_range(3))
               0: row.value = $urandom;
               1: row.value = $urandom_range(20);
               2: row.value = ~32'($urandom_range(20));
               default: row.value = {16'($urandom), 1'($urandom_range(1)), 15'($urandom_range(3))};
            endcase
            send_field(row);
         end
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
